/* rtl/core/hase_pkg.sv */
package hase_pkg;

  // Speed divider width
  localparam int unsigned DIV_W = 40;

  // Direction codes as carried on the rotation output
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_FWD  = 2'b01;
  localparam logic [1:0] DIR_REV  = 2'b11;

  localparam logic [2:0] NO_SECTOR = 3'd7;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_EDGE = 2'd1,
    OP_TICK = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic [1:0] REG_OFFSET = 2'd0;
  localparam logic [1:0] REG_STEP   = 2'd1;
  localparam logic [1:0] REG_NUM    = 2'd2;
  localparam logic [1:0] REG_STALL  = 2'd3;

  typedef struct packed {
    logic  capture;
    logic  apply;
    logic  avg_lo;
    logic  avg_hi;
    logic  div_start;
    logic  ld_spd;
    logic  mul;
    logic  ip_mul;
    logic  ld_ip;
    logic  load_out;
  } cmd_t;

  typedef struct packed {
    logic avg_needed;
    logic div_done;
    logic out_free;
  } status_t;

  // Hall code to sector number, forward order 5,1,3,2,6,4
  function automatic logic [2:0] sector_of_hall(input logic [2:0] hall);
    logic [2:0] s;
    unique case (hall)
      3'd1:    s = 3'd1;
      3'd2:    s = 3'd3;
      3'd3:    s = 3'd2;
      3'd4:    s = 3'd5;
      3'd5:    s = 3'd0;
      3'd6:    s = 3'd4;
      default: s = NO_SECTOR;
    endcase
    return s;
  endfunction

  function automatic logic [15:0] sector_start(input logic [2:0] s);
    logic [15:0] a;
    unique case (s)
      3'd0:    a = 16'd0;
      3'd1:    a = 16'd10923;
      3'd2:    a = 16'd21845;
      3'd3:    a = 16'd32768;
      3'd4:    a = 16'd43691;
      3'd5:    a = 16'd54613;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

  function automatic logic [15:0] sector_mid(input logic [2:0] s);
    logic [15:0] a;
    unique case (s)
      3'd0:    a = 16'd5461;
      3'd1:    a = 16'd16384;
      3'd2:    a = 16'd27307;
      3'd3:    a = 16'd38229;
      3'd4:    a = 16'd49152;
      3'd5:    a = 16'd60075;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

  // Next sector forward and backward (mod 6)
  function automatic logic [2:0] sector_next(input logic [2:0] s);
    return (s == 3'd5) ? 3'd0 : s + 3'd1;
  endfunction

  function automatic logic [2:0] sector_prev(input logic [2:0] s);
    return (s == 3'd0) ? 3'd5 : s - 3'd1;
  endfunction

  // Quarter-wave sine in Q14 via Q30 series; used for table constants only
  function automatic logic [15:0] sine_q14(input logic [14:0] p);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (64'(p) * 64'd1686629713) >> 14;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd110;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
    s  = (((x * t) >> 30) + 64'd32768) >> 16;
    if (s > 64'd16384) begin
      s = 64'd16384;
    end
    return s[15:0];
  endfunction

  // Signed Q14 sine of a full-turn phase
  function automatic logic [15:0] table_sine(input logic [15:0] phase);
    logic [1:0]  q;
    logic [14:0] r;
    logic [15:0] m;
    q = phase[15:14];
    r = {1'b0, phase[13:0]};
    m = q[0] ? sine_q14(15'd16384 - r) : sine_q14(r);
    return q[1] ? (16'd0 - m) : m;
  endfunction

endpackage

/* rtl/core/hase_div.sv */
// Restoring divider, one quotient bit per cycle
module hase_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hase_pkg::DIV_W-1:0]   dividend_i,
  input  logic [hase_pkg::DIV_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [hase_pkg::DIV_W-1:0]   quotient_o
);

  localparam int unsigned W  = hase_pkg::DIV_W;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dvs_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          qbit;

  // One shift-subtract step
  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    diff  = trial - {1'b0, dvs_q};
    qbit  = (trial >= {1'b0, dvs_q});
  end

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = qbit ? diff[W-1:0] : trial[W-1:0];
      quo_d = {quo_q[W-2:0], qbit};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/core/hase_dp.sv */
// Angle/speed state, arithmetic, sine table and result register
module hase_dp #(
  parameter int unsigned AVG_COUNT       = 8,
  parameter int unsigned TICK_PRESCALE   = 500,
  parameter int unsigned SINE_TABLE_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hase_pkg::cmd_t        cmd_i,
  output hase_pkg::status_t     status_o,
  input  logic [1:0]            op_i,
  input  logic [2:0]            hall_state_i,
  input  logic [31:0]           capture_period_i,
  input  logic [15:0]           offset_angle_i,
  input  logic [11:0]           step_angle_i,
  input  logic [39:0]           speed_numerator_i,
  input  logic [15:0]           stall_limit_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [15:0]           angle_o,
  output logic signed [15:0]    sine_o,
  output logic signed [15:0]    cosine_o,
  output logic signed [15:0]    speed_o,
  output logic signed [1:0]     rotation_o,
  output logic                  bad_transition_o
);

  localparam int unsigned W    = hase_pkg::DIV_W;
  localparam int unsigned TB   = SINE_TABLE_BITS;
  localparam int unsigned TN   = 1 << TB;

  // Reciprocals for the fixed divisors, exact over the operand ranges:
  // period sum (below 2^36) by AVG_COUNT, scaled product (below 2^31) by TICK_PRESCALE
  localparam int unsigned AVG_S = 36 + $clog2(AVG_COUNT);
  localparam logic [36:0] AVG_M =
    37'(((64'd1 << AVG_S) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT));
  localparam int unsigned TP_S  = 31 + $clog2(TICK_PRESCALE);
  localparam logic [31:0] TP_M  =
    32'(((64'd1 << TP_S) + 64'(TICK_PRESCALE) - 64'd1) / 64'(TICK_PRESCALE));

  // Captured request
  hase_pkg::op_e op_q;
  logic [2:0]    hall_q;
  logic [31:0]   cap_q;

  // Estimator state
  logic [2:0]  last_hall_q;
  logic [15:0] angle_q, angle_d;
  logic [1:0]  dir_q, dir_d;
  logic [3:0]  edge_cnt_q, edge_cnt_d;
  logic [35:0] psum_q, psum_d;
  logic [15:0] speed_q, speed_d;
  logic [15:0] ip_q;
  logic [15:0] icnt_q, icnt_d;
  logic        irun_q, irun_d;
  logic [15:0] stall_q, stall_d;
  logic        bad_q, bad_d;

  // Average working registers
  logic [35:0] avg_q;
  logic [54:0] avg_acc_q;
  logic [46:0] prod_q;
  logic [62:0] ipx_q;

  // Divider
  logic [W-1:0] div_dvd, div_dvs, quo;
  logic         div_done;

  // Result register
  logic        ovalid_q;
  logic [15:0] oangle_q, osin_q, ocos_q, ospeed_q;
  logic [1:0]  orot_q;
  logic        obad_q;

  logic [2:0]  sn, sp;
  logic [15:0] stall_inc;
  logic        run_tick;
  logic [72:0] avg_full;
  logic [72:0] avg_sh;
  logic [14:0] step6;
  logic [62:0] ip_full;
  logic [16:0] cap_mag;
  logic        avg_zero;

  // Request decode and state update
  always_comb begin
    sn = hase_pkg::sector_of_hall(hall_q);
    sp = hase_pkg::sector_of_hall(last_hall_q);
    stall_inc = (stall_q != 16'hFFFF) ? stall_q + 16'd1 : stall_q;
    run_tick  = irun_q && (stall_inc < stall_limit_i);

    angle_d    = angle_q;
    dir_d      = dir_q;
    edge_cnt_d = edge_cnt_q;
    psum_d     = psum_q;
    speed_d    = speed_q;
    icnt_d     = icnt_q;
    irun_d     = irun_q;
    stall_d    = stall_q;
    bad_d      = 1'b0;

    unique case (op_q)
      hase_pkg::OP_INIT: begin
        if (sn != hase_pkg::NO_SECTOR) begin
          angle_d = offset_angle_i + hase_pkg::sector_mid(sn);
        end
      end
      hase_pkg::OP_EDGE: begin
        stall_d = '0;
        if (sn != hase_pkg::NO_SECTOR && sp != hase_pkg::NO_SECTOR &&
            sp == hase_pkg::sector_prev(sn)) begin
          dir_d   = hase_pkg::DIR_FWD;
          angle_d = offset_angle_i + hase_pkg::sector_start(sn);
        end else if (sn != hase_pkg::NO_SECTOR && sp != hase_pkg::NO_SECTOR &&
                     sp == hase_pkg::sector_next(sn)) begin
          dir_d   = hase_pkg::DIR_REV;
          angle_d = offset_angle_i + hase_pkg::sector_start(hase_pkg::sector_next(sn));
        end else begin
          bad_d = 1'b1;
        end
        psum_d = psum_q + 36'(cap_q);
        if (5'(edge_cnt_q) + 5'd1 < 5'(AVG_COUNT)) begin
          edge_cnt_d = edge_cnt_q + 4'd1;
        end
      end
      hase_pkg::OP_TICK: begin
        stall_d = stall_inc;
        if (stall_inc >= stall_limit_i) begin
          speed_d = '0;
          irun_d  = 1'b0;
        end
        if (run_tick) begin
          if (icnt_q >= ip_q) begin
            icnt_d = '0;
            if (dir_q == hase_pkg::DIR_FWD) begin
              angle_d = angle_q + 16'(step_angle_i);
            end else if (dir_q == hase_pkg::DIR_REV) begin
              angle_d = angle_q - 16'(step_angle_i);
            end
          end else begin
            icnt_d = icnt_q + 16'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // Fixed-divisor arithmetic: average from two partial products, period scaling
  always_comb begin
    avg_full = {55'(psum_q[35:18]) * 55'(AVG_M), 18'd0} + 73'(avg_acc_q);
    avg_sh   = avg_full >> AVG_S;
    step6    = 15'({step_angle_i, 2'b00}) + 15'({step_angle_i, 1'b0});
    ip_full  = ipx_q >> TP_S;
  end

  // Divider operands: speed only
  assign div_dvd = speed_numerator_i;
  assign div_dvs = W'(avg_q);

  hase_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Speed saturation
  always_comb begin
    cap_mag  = (dir_q == hase_pkg::DIR_FWD) ? 17'd32767 : 17'd32768;
    avg_zero = (avg_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_hall_q <= '0;
      angle_q     <= '0;
      dir_q       <= hase_pkg::DIR_NONE;
      edge_cnt_q  <= '0;
      psum_q      <= '0;
      speed_q     <= '0;
      ip_q        <= '0;
      icnt_q      <= '0;
      irun_q      <= 1'b0;
      stall_q     <= '0;
      bad_q       <= 1'b0;
      ovalid_q    <= 1'b0;
    end else begin
      if (cmd_i.apply) begin
        if (op_q == hase_pkg::OP_EDGE) begin
          last_hall_q <= hall_q;
        end
        angle_q    <= angle_d;
        dir_q      <= dir_d;
        edge_cnt_q <= edge_cnt_d;
        psum_q     <= psum_d;
        speed_q    <= speed_d;
        icnt_q     <= icnt_d;
        irun_q     <= irun_d;
        stall_q    <= stall_d;
        bad_q      <= bad_d;
      end
      if (cmd_i.ld_spd) begin
        if (dir_q == hase_pkg::DIR_NONE) begin
          speed_q <= '0;
        end else begin
          logic [16:0] mag;
          mag = (avg_zero || quo > W'(cap_mag)) ? cap_mag : quo[16:0];
          speed_q <= (dir_q == hase_pkg::DIR_FWD) ? mag[15:0] : 16'(17'd0 - mag);
        end
      end
      if (cmd_i.ld_ip) begin
        ip_q       <= (ip_full > 63'hFFFF) ? 16'hFFFF : ip_full[15:0];
        icnt_q     <= '0;
        irun_q     <= 1'b1;
        psum_q     <= '0;
        edge_cnt_q <= '0;
      end
      if (cmd_i.load_out) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= hase_pkg::op_e'(op_i);
      hall_q <= hall_state_i;
      cap_q  <= capture_period_i;
    end
    if (cmd_i.avg_lo) begin
      avg_acc_q <= 55'(psum_q[17:0]) * 55'(AVG_M);
    end
    if (cmd_i.avg_hi) begin
      avg_q <= avg_sh[35:0];
    end
    // average fits 32 bits, so the product stays below 2^47
    if (cmd_i.mul) begin
      prod_q <= 47'(avg_q[31:0]) * 47'(step6);
    end
    if (cmd_i.ip_mul) begin
      ipx_q <= 63'(prod_q[46:16]) * 63'(TP_M);
    end
  end

  // Sine table, one entry per top-bits phase
  logic [15:0]   sin_tab [TN];
  logic [TB-1:0] sidx, cidx;

  for (genvar k = 0; k < TN; k++) begin : g_tab
    assign sin_tab[k] = hase_pkg::table_sine(16'(k << (16 - TB)));
  end

  assign sidx = angle_q[15 -: TB];
  assign cidx = sidx + TB'(TN / 4);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      oangle_q <= angle_q;
      osin_q   <= sin_tab[sidx];
      ocos_q   <= sin_tab[cidx];
      ospeed_q <= speed_q;
      orot_q   <= dir_q;
      obad_q   <= bad_q;
    end
  end

  assign status_o.avg_needed = (op_q == hase_pkg::OP_EDGE) &&
                               (5'(edge_cnt_q) + 5'd1 >= 5'(AVG_COUNT));
  assign status_o.div_done   = div_done;
  assign status_o.out_free   = !ovalid_q || out_ready_i;

  assign out_valid_o      = ovalid_q;
  assign angle_o          = oangle_q;
  assign sine_o           = osin_q;
  assign cosine_o         = ocos_q;
  assign speed_o          = ospeed_q;
  assign rotation_o       = orot_q;
  assign bad_transition_o = obad_q;

endmodule

/* rtl/core/hase_ctrl.sv */
// Sequencer: request, update, averaging arithmetic, result
module hase_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hase_pkg::status_t  status_i,
  output hase_pkg::cmd_t     cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b0000000001,
    ST_APPLY     = 10'b0000000010,
    ST_AVG_LO    = 10'b0000000100,
    ST_AVG_HI    = 10'b0000001000,
    ST_SPD_START = 10'b0000010000,
    ST_SPD_WAIT  = 10'b0000100000,
    ST_MUL       = 10'b0001000000,
    ST_IP_MUL    = 10'b0010000000,
    ST_IP_LD     = 10'b0100000000,
    ST_DONE      = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d = status_i.avg_needed ? ST_AVG_LO : ST_DONE;
      end
      // average by reciprocal, low then high half of the sum
      ST_AVG_LO: begin
        cmd_o.avg_lo = 1'b1;
        state_d = ST_AVG_HI;
      end
      ST_AVG_HI: begin
        cmd_o.avg_hi = 1'b1;
        state_d = ST_SPD_START;
      end
      ST_SPD_START: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_SPD_WAIT;
      end
      ST_SPD_WAIT: begin
        cmd_o.ld_spd = status_i.div_done;
        if (status_i.div_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_IP_MUL;
      end
      ST_IP_MUL: begin
        cmd_o.ip_mul = 1'b1;
        state_d = ST_IP_LD;
      end
      ST_IP_LD: begin
        cmd_o.ld_ip = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        cmd_o.load_out = status_i.out_free;
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

/* rtl/core/hall_angle_speed_estimator_top.sv */
// Hall angle and speed estimator.
// A request passes ST_APPLY and ST_DONE for init, tick, op 3 and a plain hall edge; a hall
// edge that closes an average also passes ST_AVG_LO, ST_AVG_HI, the 40-step speed divide,
// ST_MUL, ST_IP_MUL and ST_IP_LD. One request at a time: the next request is taken once
// the result is loaded, which waits while an earlier result waits for out_ready_i.
// Reset (rst_ni, async low) clears control and estimator state and loads the register defaults.
module hall_angle_speed_estimator_top #(
  parameter int unsigned AVG_COUNT       = 8,
  parameter int unsigned TICK_PRESCALE   = 500,
  parameter int unsigned SINE_TABLE_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [2:0]         hall_state_i,
  input  logic [31:0]        capture_period_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        angle_o,
  output logic signed [15:0] sine_o,
  output logic signed [15:0] cosine_o,
  output logic signed [15:0] speed_o,
  output logic signed [1:0]  rotation_o,
  output logic               bad_transition_o
);

  logic [15:0] offset_q;
  logic [11:0] step_q;
  logic [39:0] num_q;
  logic [15:0] stall_lim_q;
  logic [1:0]  reg_idx;
  logic        wr_en;

  hase_pkg::cmd_t    cmd;
  hase_pkg::status_t status;

  // Configuration registers
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= 16'd0;
      step_q      <= 12'd182;
      num_q       <= 40'd72000000;
      stall_lim_q <= 16'd7000;
    end else if (wr_en) begin
      unique case (reg_idx)
        hase_pkg::REG_OFFSET: offset_q    <= pwdata[15:0];
        hase_pkg::REG_STEP:   step_q      <= pwdata[11:0];
        hase_pkg::REG_NUM:    num_q       <= pwdata[39:0];
        default:              stall_lim_q <= pwdata[15:0];
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      hase_pkg::REG_OFFSET: prdata = 64'(offset_q);
      hase_pkg::REG_STEP:   prdata = 64'(step_q);
      hase_pkg::REG_NUM:    prdata = 64'(num_q);
      default:              prdata = 64'(stall_lim_q);
    endcase
  end

  hase_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hase_dp #(
    .AVG_COUNT       (AVG_COUNT),
    .TICK_PRESCALE   (TICK_PRESCALE),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .op_i              (op_i),
    .hall_state_i      (hall_state_i),
    .capture_period_i  (capture_period_i),
    .offset_angle_i    (offset_q),
    .step_angle_i      (step_q),
    .speed_numerator_i (num_q),
    .stall_limit_i     (stall_lim_q),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .angle_o           (angle_o),
    .sine_o            (sine_o),
    .cosine_o          (cosine_o),
    .speed_o           (speed_o),
    .rotation_o        (rotation_o),
    .bad_transition_o  (bad_transition_o)
  );

endmodule

/* tb/hase_checker.sv */
module hase_checker
  import hase_pkg::*;
#(
  parameter int unsigned AVG_COUNT       = 8,
  parameter int unsigned TICK_PRESCALE   = 500,
  parameter int unsigned SINE_TABLE_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         op_i,
  input  logic [2:0]         hall_state_i,
  input  logic [31:0]        capture_period_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [15:0]        angle_i,
  input  logic signed [15:0] sine_i,
  input  logic signed [15:0] cosine_i,
  input  logic signed [15:0] speed_i,
  input  logic signed [1:0]  rotation_i,
  input  logic               bad_transition_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [15:0] angle;
    logic [15:0] sine;
    logic [15:0] cosine;
    logic [15:0] speed;
    logic [1:0]  rotation;
    logic        bad;
  } estimate_t;

  // Sector tables in forward order
  localparam logic [15:0] SECT_START [6] = '{0, 10923, 21845, 32768, 43691, 54613};
  localparam logic [15:0] SECT_MID   [6] = '{5461, 16384, 27307, 38229, 49152, 60075};
  localparam logic [2:0]  HALL_SECT  [8] = '{7, 1, 3, 2, 5, 0, 4, 7};

  // Configuration copy
  logic [15:0] cfg_offset;
  logic [11:0] cfg_step;
  logic [39:0] cfg_num;
  logic [15:0] cfg_stall;

  // Estimator state copy
  logic [2:0]  prev_hall;
  logic [15:0] est_angle;
  logic [1:0]  est_dir;
  logic [3:0]  edges_seen;
  logic [35:0] period_acc;
  logic [15:0] est_speed;
  logic [15:0] step_period;
  logic [15:0] step_count;
  logic        stepping;
  logic [15:0] idle_ticks;

  estimate_t expected_q[$];

  // sin(pi/2 * p/16384) in Q14, series in Q30
  function automatic logic [15:0] quarter_sine(input int unsigned p);
    longint unsigned x, x2, t, s;
    int unsigned div [5] = '{110, 72, 42, 20, 6};
    x  = (longint'(p) * 64'd1686629713) >> 14;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    for (int k = 0; k < 5; k++) begin
      t = (64'd1 << 30) - ((x2 * t) >> 30) / div[k];
    end
    s = (((x * t) >> 30) + 64'd32768) >> 16;
    if (s > 64'd16384) begin
      s = 64'd16384;
    end
    return s[15:0];
  endfunction

  function automatic logic [15:0] turn_sine(input logic [15:0] ph);
    logic [15:0] m;
    m = ph[14] ? quarter_sine(16384 - ph[13:0]) : quarter_sine(ph[13:0]);
    return ph[15] ? 16'd0 - m : m;
  endfunction

  // Close an averaging window: speed and interpolation period
  task automatic close_average();
    longint unsigned avg, mag, lim, ip;
    avg = period_acc / AVG_COUNT;
    if (est_dir == DIR_NONE) begin
      est_speed = '0;
    end else begin
      lim = (est_dir == DIR_FWD) ? 32767 : 32768;
      mag = (avg == 0) ? lim : cfg_num / avg;
      if (mag > lim) mag = lim;
      est_speed = (est_dir == DIR_FWD) ? mag[15:0] : 16'd0 - mag[15:0];
    end
    ip = (avg * cfg_step * 6) / (longint'(TICK_PRESCALE) * 65536);
    step_period = (ip > 65535) ? 16'hFFFF : ip[15:0];
    step_count  = '0;
    stepping    = 1'b1;
    period_acc  = '0;
    edges_seen  = '0;
  endtask

  // Advance the state copy by one request and return its result
  task automatic estimate_request(input logic [1:0] op, input logic [2:0] hall,
                                  input logic [31:0] cap, output estimate_t res);
    logic [2:0]  sn, sp;
    logic        bad;
    logic [15:0] ph;
    sn  = HALL_SECT[hall];
    bad = 1'b0;
    case (op_e'(op))
      OP_INIT: begin
        if (sn != NO_SECTOR) est_angle = cfg_offset + SECT_MID[sn];
      end
      OP_EDGE: begin
        sp = HALL_SECT[prev_hall];
        idle_ticks = '0;
        if (sn != NO_SECTOR && sp != NO_SECTOR && sp == (sn + 5) % 6) begin
          est_dir   = DIR_FWD;
          est_angle = cfg_offset + SECT_START[sn];
        end else if (sn != NO_SECTOR && sp != NO_SECTOR && sp == (sn + 1) % 6) begin
          est_dir   = DIR_REV;
          est_angle = cfg_offset + SECT_START[(sn + 1) % 6];
        end else begin
          bad = 1'b1;
        end
        prev_hall  = hall;
        period_acc = period_acc + cap;
        if (edges_seen + 1 < AVG_COUNT) edges_seen++;
        else close_average();
      end
      OP_TICK: begin
        if (idle_ticks != 16'hFFFF) idle_ticks++;
        if (idle_ticks >= cfg_stall) begin
          est_speed = '0;
          stepping  = 1'b0;
        end
        if (stepping) begin
          if (step_count >= step_period) begin
            step_count = '0;
            if (est_dir == DIR_FWD) est_angle = est_angle + cfg_step;
            else if (est_dir == DIR_REV) est_angle = est_angle - cfg_step;
          end else begin
            step_count++;
          end
        end
      end
      default: ;
    endcase
    ph = (est_angle >> (16 - SINE_TABLE_BITS)) << (16 - SINE_TABLE_BITS);
    res.angle    = est_angle;
    res.sine     = turn_sine(ph);
    res.cosine   = turn_sine(ph + 16'd16384);
    res.speed    = est_speed;
    res.rotation = est_dir;
    res.bad      = bad;
  endtask

  // Watch the channels, predict and compare
  always @(posedge clk_i or negedge rst_ni) begin
    estimate_t exp_r, got_r;
    if (!rst_ni) begin
      cfg_offset  = '0;
      cfg_step    = 12'd182;
      cfg_num     = 40'd72000000;
      cfg_stall   = 16'd7000;
      prev_hall   = '0;
      est_angle   = '0;
      est_dir     = DIR_NONE;
      edges_seen  = '0;
      period_acc  = '0;
      est_speed   = '0;
      step_period = '0;
      step_count  = '0;
      stepping    = 1'b0;
      idle_ticks  = '0;
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          REG_OFFSET: cfg_offset = pwdata[15:0];
          REG_STEP:   cfg_step   = pwdata[11:0];
          REG_NUM:    cfg_num    = pwdata[39:0];
          REG_STALL:  cfg_stall  = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        estimate_request(op_i, hall_state_i, capture_period_i, exp_r);
        expected_q.push_back(exp_r);
      end
      if (out_valid_i && out_ready_i) begin
        got_r = '{angle_i, sine_i, cosine_i, speed_i, rotation_i, bad_transition_i};
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result: %p", got_r);
        end else begin
          exp_r = expected_q.pop_front();
          if (got_r !== exp_r) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("mismatch: angle %0d/%0d sin %0d/%0d cos %0d/%0d",
                       exp_r.angle, got_r.angle, $signed(exp_r.sine),
                       $signed(got_r.sine), $signed(exp_r.cosine), $signed(got_r.cosine));
              $display("  speed %0d/%0d rot %0d/%0d bad %0d/%0d (expected/actual)",
                       $signed(exp_r.speed), $signed(got_r.speed), exp_r.rotation,
                       got_r.rotation, exp_r.bad, got_r.bad);
            end
          end
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

/* tb/tb_hall_angle_speed_estimator_top.sv */
module tb_hall_angle_speed_estimator_top;
  import hase_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int PHASE_REQS = 430;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         op_i = OP_NOP;
  logic [2:0]         hall_state_i = '0;
  logic [31:0]        capture_period_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [15:0]        angle_o;
  logic signed [15:0] sine_o;
  logic signed [15:0] cosine_o;
  logic signed [15:0] speed_o;
  logic signed [1:0]  rotation_o;
  logic               bad_transition_o;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;
  bit                 stim_busy;

  // Forward hall order, sectors 0..5
  localparam logic [2:0] FWD_HALL [6] = '{5, 1, 3, 2, 6, 4};
  int sect_pos;
  int spin;

  hall_angle_speed_estimator_top dut (.*);

  hase_checker chk (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_i(in_ready_o), .op_i, .hall_state_i, .capture_period_i,
    .out_valid_i(out_valid_o), .out_ready_i, .angle_i(angle_o), .sine_i(sine_o),
    .cosine_i(cosine_o), .speed_i(speed_o), .rotation_i(rotation_o),
    .bad_transition_i(bad_transition_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("hall_angle_speed_estimator_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly short gaps, a few long ones, sometimes none in a burst
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side back-pressure
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i = 1'b1;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
      repeat (n) @(negedge clk_i);
      n = gap_len();
      if (n > 0) begin
        out_ready_i = 1'b0;
        repeat (n) @(negedge clk_i);
      end
    end
  end

  task automatic send(input op_e op, input logic [2:0] hall, input logic [31:0] cap);
    int g;
    g = stim_busy ? 0 : gap_len();
    repeat (g) @(negedge clk_i);
    in_valid_i       = 1'b1;
    op_i             = op;
    hall_state_i     = hall;
    capture_period_i = cap;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    op_i       = OP_NOP;
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] offs, input logic [11:0] stp,
                            input logic [39:0] num, input logic [15:0] stall);
    drain();
    reg_write(REG_OFFSET, 64'(offs));
    reg_write(REG_STEP, 64'(stp));
    reg_write(REG_NUM, 64'(num));
    reg_write(REG_STALL, 64'(stall));
  endtask

  function automatic logic [31:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom();
    if (r < 30) return $urandom_range(0, 3000);
    if (r < 33) return 32'hFFFF_FFFF;
    return $urandom_range(1000, 400000);
  endfunction

  // Random requests: mostly clean rotation with ticks, some noise
  task automatic random_phase(input int count);
    int done, r;
    logic [2:0] h;
    done = 0;
    while (done < count) begin
      stim_busy = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send(OP_INIT, 3'($urandom_range(0, 7)), $urandom());
      end else if (r < 50) begin
        if ($urandom_range(0, 19) == 0) spin = -spin;
        if ($urandom_range(0, 9) == 0) begin
          h = 3'($urandom_range(0, 7));
        end else begin
          sect_pos = (sect_pos + spin + 6) % 6;
          h = FWD_HALL[sect_pos];
        end
        send(OP_EDGE, h, pick_period());
        for (int k = 0; k < 6; k++) if (FWD_HALL[k] == h) sect_pos = k;
      end else if (r < 97) begin
        send(OP_TICK, 3'($urandom_range(0, 7)), $urandom());
      end else begin
        send(OP_NOP, 3'($urandom_range(0, 7)), $urandom());
        done--;
      end
      done++;
    end
    stim_busy = 1'b0;
  endtask

  initial begin
    sect_pos  = 0;
    spin      = 1;
    stim_busy = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset values, init from every hall code
    send(OP_NOP, 3'd0, 32'd0);
    for (int h = 0; h < 8; h++) send(OP_INIT, 3'(h), 32'd0);
    // Edge from an undefined previous state, then a forward window closing an average
    send(OP_EDGE, 3'd5, 32'hFFFF_FFFF);
    send(OP_EDGE, 3'd1, 32'd0);
    send(OP_EDGE, 3'd3, 32'd5000);
    send(OP_EDGE, 3'd2, 32'd5000);
    send(OP_EDGE, 3'd6, 32'd5000);
    send(OP_EDGE, 3'd4, 32'd5000);
    send(OP_EDGE, 3'd5, 32'd5000);
    send(OP_EDGE, 3'd1, 32'd5000);
    // Reverse, repeated state, invalid codes, non-neighbor jump
    send(OP_EDGE, 3'd5, 32'd0);
    send(OP_EDGE, 3'd5, 32'd0);
    send(OP_EDGE, 3'd0, 32'd0);
    send(OP_EDGE, 3'd7, 32'd0);
    send(OP_EDGE, 3'd1, 32'd0);
    send(OP_EDGE, 3'd6, 32'd0);
    for (int k = 0; k < 4; k++) send(OP_TICK, 3'd0, 32'd0);

    random_phase(PHASE_REQS);
    // Extremes, stall on every tick
    set_config(16'hFFFF, 12'd4095, 40'hFF_FFFF_FFFF, 16'd1);
    random_phase(PHASE_REQS);
    set_config(16'd0, 12'd1, 40'd1, 16'hFFFF);
    random_phase(PHASE_REQS);
    set_config(16'($urandom()), 12'($urandom_range(1, 4095)),
               {8'($urandom_range(0, 255)), $urandom()}, 16'($urandom_range(2, 40)));
    random_phase(PHASE_REQS);

    drain();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("hall_angle_speed_estimator_top verification clean");
    end else begin
      $display("hall_angle_speed_estimator_top verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/hase_pkg.sv
rtl/core/hase_div.sv
rtl/core/hase_dp.sv
rtl/core/hase_ctrl.sv
rtl/core/hall_angle_speed_estimator_top.sv
tb/hase_checker.sv
tb/tb_hall_angle_speed_estimator_top.sv
